@@ rtl/mbf_pkg.sv @@
// shared types, codes and helpers for the mbf float alu
package mbf_pkg;

  // operation codes
  localparam logic [1:0] KindAdd = 2'd0;
  localparam logic [1:0] KindSub = 2'd1;
  localparam logic [1:0] KindMul = 2'd2;
  localparam logic [1:0] KindDiv = 2'd3;

  // error codes
  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrOvf  = 2'd1;
  localparam logic [1:0] ErrUnf  = 2'd2;
  localparam logic [1:0] ErrDivz = 2'd3;

  localparam logic [23:0] MantHidden = 24'h800000;
  localparam logic [23:0] MantMax    = 24'hFFFFFF;
  localparam logic [7:0]  ExpMax     = 8'hFF;

  // input beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } mbf_in_t;

  // result beat
  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  error_code;
  } mbf_out_t;

  // request to the shared adder
  typedef struct packed {
    logic [24:0] a;
    logic [24:0] b;
    logic        sub;
  } mbf_unit_req_t;

  // pack sign, exponent and mantissa into a word
  function automatic logic [31:0] mbf_pack(input logic neg, input logic [7:0] e,
                                           input logic [23:0] m);
    mbf_pack = {e, neg, m[22:0]};
  endfunction

  // 24-bit mantissa with hidden one
  function automatic logic [23:0] mbf_mant(input logic [31:0] x);
    mbf_mant = {1'b1, x[22:0]};
  endfunction

endpackage

@@ rtl/mbf_alu_unit.sv @@
// shared 25-bit add / subtract unit with carry out
module mbf_alu_unit
  import mbf_pkg::*;
(
  input  mbf_unit_req_t req_i,
  output logic [25:0]   sum_o
);

  // subtract as add of inverted operand plus one; bit 25 is carry / no borrow
  assign sum_o = {1'b0, req_i.a} + {1'b0, req_i.b ^ {25{req_i.sub}}} + {25'd0, req_i.sub};

endmodule

@@ rtl/mbf_float_alu_top.sv @@
// top level: sequencer and registers of the mbf float alu around a shared adder
//
// Usage: present an operation on op_i and raise start; the beat is taken at a
// rising edge where start is high and busy is low. busy stays high while the
// sequencer works, and the result beat appears on res_o, where it is marked by
// done_o for exactly one cycle. The receiver cannot stall; done_o is a strobe.
// A new start is taken in the same cycle as done_o is shown.
// Sequence per beat, all through one 25-bit adder used once a cycle:
//   trivial cases (zero operands, range errors, far operands): answered from idle
//   add / subtract: add or subtract, then one bit of renormalizing shift per step
//   multiply: 3 bytes, each fetched and then added bit by bit (a zero byte is
//     skipped at once), then a normalizing shift (at most one), rounding and range check
//   divide: 25 restoring steps, then a finishing step
// Reset (rst_ni low) returns the sequencer to idle and drops done_o; no
// state is kept between beats.
module mbf_float_alu_top
  import mbf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  mbf_in_t  op_i,
  output logic     done_o,
  output mbf_out_t res_o
);

  typedef enum logic [3:0] {
    StIdle, StAddOp, StAddRev, StAddNorm, StMulByte, StMulBit,
    StMulNorm, StMulRound, StDivStep, StDivFin
  } state_e;

  state_e        st_q, st_d;
  logic          done_q, done_d;
  mbf_out_t      res_q, res_d;
  logic [24:0]   m_q, m_d;
  logic [23:0]   x_q, x_d;
  logic [23:0]   fm_q, fm_d;
  logic [31:0]   w_q, w_d;
  logic [7:0]    fb_q, fb_d;
  logic          cy_q, cy_d;
  logic [1:0]    k_q, k_d;
  logic [4:0]    cnt_q, cnt_d;
  logic signed [9:0] e_q, e_d;
  logic          neg_q, neg_d;
  logic          negb_q, negb_d;
  logic          esub_q, esub_d;

  mbf_unit_req_t req;
  logic [25:0]   sum;

  mbf_alu_unit u_unit (.req_i(req), .sum_o(sum));

  // adder operand select
  always_comb begin
    req = '{a: m_q, b: {1'b0, x_q}, sub: 1'b0};
    unique case (st_q)
      StAddOp:    req = '{a: m_q, b: {1'b0, x_q}, sub: esub_q};
      StAddRev:   req = '{a: {1'b0, x_q}, b: m_q, sub: 1'b1};
      StMulBit:   req = '{a: {1'b0, w_q[31:8]}, b: {1'b0, x_q}, sub: 1'b0};
      StMulRound: req = '{a: {1'b0, w_q[31:8]}, b: 25'd1, sub: 1'b0};
      StDivStep:  req = '{a: {m_q[23:0], (cnt_q == 5'd0) ? cy_q : 1'b0},
                          b: {1'b0, x_q}, sub: 1'b1};
      default:    req = '{a: m_q, b: {1'b0, x_q}, sub: 1'b0};
    endcase
  end

  // sequencer next state
  always_comb begin
    logic [31:0] a, b, big, sml;
    logic [7:0]  gap, fb;
    logic [23:0] acc, rm;
    logic        c, rbig;
    logic signed [9:0] en;
    st_d = st_q; done_d = 1'b0; res_d = res_q;
    m_d = m_q; x_d = x_q; fm_d = fm_q; w_d = w_q; fb_d = fb_q; cy_d = cy_q;
    k_d = k_q; cnt_d = cnt_q; e_d = e_q; neg_d = neg_q; negb_d = negb_q;
    esub_d = esub_q;
    a = op_i.operand_a; b = op_i.operand_b; big = '0; sml = '0; gap = '0; fb = '0;
    acc = '0; rm = '0; c = 1'b0; rbig = 1'b0; en = '0;
    unique case (st_q)
      StIdle: begin
        if (start) begin
          if (op_i.kind == KindSub && b[31:24] != 8'd0) b[23] = ~b[23];
          neg_d = a[23] ^ b[23];
          unique case (op_i.kind)
            KindAdd, KindSub: begin
              if (a[31:24] == 8'd0) begin
                res_d = '{result_value: b, error_code: ErrNone}; done_d = 1'b1;
              end else if (b[31:24] == 8'd0) begin
                res_d = '{result_value: a, error_code: ErrNone}; done_d = 1'b1;
              end else begin
                if (b[31:24] > a[31:24]) begin
                  big = b; sml = a;
                end else begin
                  big = a; sml = b;
                end
                gap = big[31:24] - sml[31:24];
                if (gap > 8'd24) begin
                  res_d = '{result_value: big, error_code: ErrNone}; done_d = 1'b1;
                end else begin
                  m_d = {1'b0, mbf_mant(big)};
                  x_d = mbf_mant(sml) >> gap[4:0];
                  e_d = signed'({2'b00, big[31:24]});
                  neg_d = big[23]; negb_d = sml[23]; esub_d = big[23] ^ sml[23];
                  st_d = StAddOp;
                end
              end
            end
            KindMul: begin
              en = signed'({2'b00, a[31:24]}) + signed'({2'b00, b[31:24]}) - 10'sd128;
              if (a[31:24] == 8'd0 || b[31:24] == 8'd0) begin
                res_d = '{result_value: 32'd0, error_code: ErrNone}; done_d = 1'b1;
              end else if (en > 10'sd255) begin
                res_d = '{result_value: mbf_pack(neg_d, ExpMax, MantMax), error_code: ErrOvf};
                done_d = 1'b1;
              end else if (en < 10'sd1) begin
                res_d = '{result_value: 32'd0, error_code: ErrUnf}; done_d = 1'b1;
              end else begin
                e_d = en; fm_d = mbf_mant(a); x_d = mbf_mant(b); w_d = '0; k_d = '0;
                st_d = StMulByte;
              end
            end
            default: begin
              if (b[31:24] == 8'd0) begin
                res_d = '{result_value: 32'd0, error_code: ErrDivz}; done_d = 1'b1;
              end else if (a[31:24] == 8'd0) begin
                res_d = '{result_value: 32'd0, error_code: ErrNone}; done_d = 1'b1;
              end else begin
                e_d = signed'({2'b00, a[31:24]}) - signed'({2'b00, b[31:24]}) + 10'sd129;
                m_d = {2'b00, 1'b1, a[22:1]}; cy_d = a[0]; x_d = mbf_mant(b);
                w_d = '0; cnt_d = '0; st_d = StDivStep;
              end
            end
          endcase
        end
      end
      // add or subtract aligned mantissas
      StAddOp: begin
        if (!esub_q) begin
          if (sum[24]) begin
            if (e_q + 10'sd1 > 10'sd255) begin
              res_d = '{result_value: mbf_pack(neg_q, ExpMax, MantMax), error_code: ErrOvf};
            end else begin
              res_d = '{result_value: mbf_pack(neg_q, e_q[7:0] + 8'd1, sum[24:1]),
                        error_code: ErrNone};
            end
          end else begin
            res_d = '{result_value: mbf_pack(neg_q, e_q[7:0], sum[23:0]), error_code: ErrNone};
          end
          done_d = 1'b1; st_d = StIdle;
        end else if (sum[25]) begin
          if (sum[24:0] == 25'd0) begin
            res_d = '{result_value: 32'd0, error_code: ErrNone}; done_d = 1'b1; st_d = StIdle;
          end else begin
            m_d = sum[24:0]; st_d = StAddNorm;
          end
        end else begin
          neg_d = negb_q; st_d = StAddRev;
        end
      end
      // smaller minus larger gave a borrow: take the reverse difference
      StAddRev: begin
        m_d = sum[24:0]; st_d = StAddNorm;
      end
      // renormalize one bit a cycle
      StAddNorm: begin
        if (m_q[23]) begin
          res_d = '{result_value: mbf_pack(neg_q, e_q[7:0], m_q[23:0]), error_code: ErrNone};
          done_d = 1'b1; st_d = StIdle;
        end else if (e_q == 10'sd1) begin
          res_d = '{result_value: 32'd0, error_code: ErrNone}; done_d = 1'b1; st_d = StIdle;
        end else begin
          m_d = {m_q[23:0], 1'b0}; e_d = e_q - 10'sd1;
        end
      end
      // fetch multiplier byte, zero byte shifts the product a byte at once
      StMulByte: begin
        unique case (k_q)
          2'd0:    fb = fm_q[7:0];
          2'd1:    fb = fm_q[15:8];
          default: fb = fm_q[23:16];
        endcase
        if (fb == 8'd0) begin
          w_d = {8'd0, w_q[31:8]};
          if (k_q == 2'd2) st_d = StMulNorm;
          else k_d = k_q + 2'd1;
        end else begin
          fb_d = fb; cy_d = 1'b0; cnt_d = '0; st_d = StMulBit;
        end
      end
      // one shift-and-add step
      StMulBit: begin
        fb_d = {cy_q, fb_q[7:1]};
        if (fb_q[0]) begin
          acc = sum[23:0]; c = sum[24];
        end else begin
          acc = w_q[31:8]; c = 1'b0;
        end
        w_d = {c, acc, w_q[7:1]};
        cy_d = w_q[0];
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[2:0] == 3'd7) begin
          if (k_q == 2'd2) st_d = StMulNorm;
          else begin
            k_d = k_q + 2'd1; st_d = StMulByte;
          end
        end
      end
      // normalize product one bit a cycle
      StMulNorm: begin
        if (!w_q[31] && w_q[31:8] != 24'd0 && e_q > 10'sd0) begin
          w_d = {w_q[30:0], 1'b0}; e_d = e_q - 10'sd1;
        end else begin
          st_d = StMulRound;
        end
      end
      // round half up and range check
      StMulRound: begin
        rm = w_q[31:8]; en = e_q;
        if (w_q[7]) begin
          rm = sum[23:0];
          if (rm == 24'd0) begin
            rm = MantHidden; en = e_q + 10'sd1;
          end
        end
        if (en < 10'sd1 || rm == 24'd0) begin
          res_d = '{result_value: 32'd0, error_code: ErrNone};
        end else if (en > 10'sd255) begin
          res_d = '{result_value: mbf_pack(neg_q, ExpMax, MantMax), error_code: ErrOvf};
        end else begin
          res_d = '{result_value: mbf_pack(neg_q, en[7:0], rm), error_code: ErrNone};
        end
        done_d = 1'b1; st_d = StIdle;
      end
      // restoring division step, one quotient bit a cycle
      StDivStep: begin
        rbig = sum[25];
        m_d = rbig ? {1'b0, sum[23:0]} : {1'b0, req.a[23:0]};
        w_d = {w_q[30:0], rbig};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd24) st_d = StDivFin;
      end
      // quotient normalize and range check
      StDivFin: begin
        if (w_q[24]) begin
          rm = w_q[24:1]; en = e_q;
        end else begin
          rm = w_q[23:0]; en = e_q - 10'sd1;
        end
        if (en > 10'sd255) begin
          res_d = '{result_value: mbf_pack(neg_q, ExpMax, MantMax), error_code: ErrOvf};
        end else if (en < 10'sd1) begin
          res_d = '{result_value: 32'd0, error_code: ErrUnf};
        end else begin
          res_d = '{result_value: mbf_pack(neg_q, en[7:0], rm), error_code: ErrNone};
        end
        done_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    // any zero goes out as all bits clear
    if (res_d.result_value[31:24] == 8'd0) res_d.result_value = 32'd0;
    if (done_d) st_d = StIdle;
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d; m_q <= m_d; x_q <= x_d; fm_q <= fm_d; w_q <= w_d; fb_q <= fb_d;
    cy_q <= cy_d; k_q <= k_d; cnt_q <= cnt_d; e_q <= e_d; neg_q <= neg_d;
    negb_q <= negb_d; esub_q <= esub_d;
  end

  assign busy   = (st_q != StIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while sequencer busy");
  a_start_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("accepted beat dropped");
  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.error_code == ErrDivz) |-> res_o.result_value == 32'd0)
    else $error("division by zero not zero");
  a_ovf_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.error_code == ErrOvf) |-> res_o.result_value[31:24] == ExpMax)
    else $error("overflow not saturated");
  a_unf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.error_code == ErrUnf) |-> res_o.result_value == 32'd0)
    else $error("underflow not zero");
`endif

endmodule

@@ tb/tb.sv @@
// testbench for the mbf float alu: random and directed operations checked against a local model
`timescale 1ns / 100ps

module tb;
  import mbf_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  mbf_in_t  op_i = '0;
  logic     done_o;
  mbf_out_t res_o;

  mbf_in_t  pending_ops[$];
  mbf_out_t expected_res[$];
  int       fail_count = 0;
  bit       stim_done = 1'b0;

  mbf_float_alu_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .op_i   (op_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #1 clk_i = ~clk_i;

  // add with alignment and renormalization
  function automatic mbf_out_t float_add(logic [31:0] a, logic [31:0] b);
    mbf_out_t r;
    logic [7:0] ea, eb, te;
    logic na, nb, tn, neg;
    logic [24:0] ma, mb, al, m, tm;
    int e, gap;
    r = '0;
    ea = a[31:24];
    eb = b[31:24];
    if (ea == 0) begin
      r.result_value = (eb == 0) ? 32'd0 : b;
      return r;
    end
    if (eb == 0) begin
      r.result_value = a;
      return r;
    end
    na = a[23];
    nb = b[23];
    ma = {2'b01, a[22:0]};
    mb = {2'b01, b[22:0]};
    if (eb > ea) begin
      te = ea; ea = eb; eb = te;
      tm = ma; ma = mb; mb = tm;
      tn = na; na = nb; nb = tn;
    end
    gap = int'(ea) - int'(eb);
    if (gap > 24) begin
      r.result_value = {ea, na, ma[22:0]};
      return r;
    end
    al = mb >> gap;
    e = int'(ea);
    if (na == nb) begin
      m = ma + al;
      neg = na;
      if (m[24]) begin
        m = m >> 1;
        e++;
        if (e > 255) begin
          r.result_value = {ExpMax, neg, MantMax[22:0]};
          r.error_code = ErrOvf;
          return r;
        end
      end
    end else begin
      if (ma >= al) begin
        m = ma - al; neg = na;
      end else begin
        m = al - ma; neg = nb;
      end
      if (m == 0) return r;
      while (!m[23]) begin
        m = m << 1;
        e--;
        if (e == 0) return r;
      end
    end
    r.result_value = {e[7:0], neg, m[22:0]};
    return r;
  endfunction

  // byte-serial shift-and-add multiply with round-half-up
  function automatic mbf_out_t float_mul(logic [31:0] a, logic [31:0] b);
    mbf_out_t r;
    logic neg;
    int e;
    logic [23:0] fm, mm;
    logic [7:0] rc, rh, rl, rb, fb, mlo, mmid, mhi;
    logic cy, nc;
    logic [16:0] s;
    logic [8:0] cs;
    logic [31:0] w;
    logic [23:0] m;
    r = '0;
    if (a[31:24] == 0 || b[31:24] == 0) return r;
    neg = a[23] ^ b[23];
    e = int'(a[31:24]) + int'(b[31:24]) - 128;
    if (e > 255) begin
      r.result_value = {ExpMax, neg, MantMax[22:0]};
      r.error_code = ErrOvf;
      return r;
    end
    if (e < 1) begin
      r.error_code = ErrUnf;
      return r;
    end
    fm = {1'b1, a[22:0]};
    mm = {1'b1, b[22:0]};
    rc = 0; rh = 0; rl = 0; rb = 0; cy = 0;
    mlo = mm[7:0]; mmid = mm[15:8]; mhi = mm[23:16];
    for (int k = 0; k < 3; k++) begin
      fb = fm[8*k +: 8];
      if (fb == 0) begin
        rb = rl; rl = rh; rh = rc; rc = 0;
        continue;
      end
      cy = 0;
      for (int i = 0; i < 8; i++) begin
        nc = fb[0];
        fb = {cy, fb[7:1]};
        cy = nc;
        if (cy) begin
          s = {1'b0, rh, rl} + {1'b0, mmid, mlo};
          rl = s[7:0];
          rh = s[15:8];
          cy = s[16];
          cs = rc + mhi + cy;
          rc = cs[7:0];
          cy = cs[8];
        end
        nc = rc[0]; rc = {cy, rc[7:1]}; cy = nc;
        nc = rh[0]; rh = {cy, rh[7:1]}; cy = nc;
        nc = rl[0]; rl = {cy, rl[7:1]}; cy = nc;
        nc = rb[0]; rb = {cy, rb[7:1]}; cy = nc;
      end
    end
    w = {rc, rh, rl, rb};
    while (!w[31] && w[31:8] != 0 && e > 0) begin
      w = w << 1;
      e--;
    end
    m = w[31:8];
    if (w[7]) begin
      m = m + 24'd1;
      if (m == 0) begin
        m = MantHidden;
        e++;
      end
    end
    if (e < 1 || m == 0) return r;
    if (e > 255) begin
      r.result_value = {ExpMax, neg, MantMax[22:0]};
      r.error_code = ErrOvf;
      return r;
    end
    r.result_value = {e[7:0], neg, m[22:0]};
    return r;
  endfunction

  // truncating 48/24 divide
  function automatic mbf_out_t float_div(logic [31:0] a, logic [31:0] b);
    mbf_out_t r;
    logic neg;
    int e;
    logic [47:0] num;
    logic [47:0] qw;
    logic [31:0] q;
    r = '0;
    if (b[31:24] == 0) begin
      r.error_code = ErrDivz;
      return r;
    end
    if (a[31:24] == 0) return r;
    neg = a[23] ^ b[23];
    e = int'(a[31:24]) - int'(b[31:24]) + 129;
    num = {1'b1, a[22:0], 24'd0};
    qw = num / {24'd0, 1'b1, b[22:0]};
    q = qw[31:0];
    if (q[24]) q = q >> 1;
    else e--;
    while (!q[23] && e > 0) begin
      q = q << 1;
      e--;
    end
    if (e > 255) begin
      r.result_value = {ExpMax, neg, MantMax[22:0]};
      r.error_code = ErrOvf;
      return r;
    end
    if (e < 1) begin
      r.error_code = ErrUnf;
      return r;
    end
    r.result_value = {e[7:0], neg, q[22:0]};
    return r;
  endfunction

  function automatic mbf_out_t alu_result(mbf_in_t op);
    mbf_out_t r;
    logic [31:0] b;
    b = op.operand_b;
    case (op.kind)
      KindAdd: r = float_add(op.operand_a, b);
      KindSub: begin
        if (b[31:24] != 0) b[23] = ~b[23];
        r = float_add(op.operand_a, b);
      end
      KindMul: r = float_mul(op.operand_a, b);
      default: r = float_div(op.operand_a, b);
    endcase
    if (r.result_value[31:24] == 0) r.result_value = 0;
    return r;
  endfunction

  // random operand with exponents biased toward interesting ranges
  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[31:24] = 8'd0;
      1: v[31:24] = 8'hFF - 8'($urandom_range(0, 3));
      2: v[31:24] = 8'($urandom_range(1, 4));
      3, 4, 5: v[31:24] = 8'd128 + 8'($urandom_range(0, 16)) - 8'd8;
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) v[22:0] = ($urandom_range(0, 1)) ? 23'h7FFFFF : 23'd0;
    return v;
  endfunction

  task automatic add_op(logic [1:0] k, logic [31:0] a, logic [31:0] b);
    mbf_in_t op;
    op.kind = k;
    op.operand_a = a;
    op.operand_b = b;
    pending_ops.push_back(op);
  endtask

  // stimulus
  initial begin
    logic [31:0] a;
    for (int k = 0; k < 4; k++) begin
      add_op(k[1:0], 32'h0, 32'h0);
      add_op(k[1:0], 32'h007FFFFF, 32'h81000000);
      add_op(k[1:0], 32'h81000000, 32'h00FFFFFF);
      add_op(k[1:0], 32'hFF7FFFFF, 32'hFFFFFFFF);
      add_op(k[1:0], 32'h01000000, 32'hFF000000);
      add_op(k[1:0], 32'h81400000, 32'h81C00000);
    end
    add_op(KindAdd, 32'h90000000, 32'h70000000);
    add_op(KindSub, 32'h81123456, 32'h81123456);
    add_op(KindSub, 32'h01800000, 32'h01FFFFFF);
    add_op(KindMul, 32'h40000000, 32'h40000000);
    add_op(KindMul, 32'h80FFFFFF, 32'h817FFFFF);
    add_op(KindMul, 32'h41000000, 32'h40000000);
    for (int i = 0; i < 1000; i++) begin
      a = rand_operand();
      add_op(2'($urandom_range(0, 3)), a,
             ($urandom_range(0, 5) == 0) ? {a[31:24] + 8'($urandom_range(0, 3)), 24'($urandom)}
                                          : rand_operand());
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    stim_done = 1'b1;
  end

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_res.push_back(alu_result(op_i));
        void'(pending_ops.pop_front());
      end
      if (start && busy) begin
        // hold the beat until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        if ((start && !busy ? pending_ops.size() : pending_ops.size()) != 0) begin
          start <= 1'b1;
          op_i <= pending_ops[0];
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(0, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mbf_out_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result beat %h", res_o);
        fail_count++;
      end else begin
        exp_r = expected_res.pop_front();
        if (res_o.result_value !== exp_r.result_value) begin
          $error("result_value expected %h actual %h", exp_r.result_value, res_o.result_value);
          fail_count++;
        end
        if (res_o.error_code !== exp_r.error_code) begin
          $error("error_code expected %0d actual %0d", exp_r.error_code, res_o.error_code);
          fail_count++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (pending_ops.size() != 0 || start || expected_res.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && expected_res.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // timeout
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ mbf_float_alu_top.f @@
rtl/mbf_pkg.sv
rtl/mbf_alu_unit.sv
rtl/mbf_float_alu_top.sv
tb/tb.sv
